/* rtl/xpd_pkg.sv */
// Shared types and constants for the XOR packet deframer.
package xpd_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_CHK_ERR  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT  = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_BASE_TO    = 2'd1;
  localparam logic [1:0] REG_PER_BYTE   = 2'd2;

  localparam int          ADDR_W        = 4;
  localparam logic [10:0] TICK_MAX      = 11'd2047;
  localparam logic [7:0]  START_RST     = 8'hAA;
  localparam logic [9:0]  BASE_RST      = 10'd10;
  localparam logic [3:0]  PER_BYTE_RST  = 4'd4;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [9:0] base_timeout_ms;
    logic [3:0] per_byte_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] source_id;
    logic [7:0] destination_id;
    logic [7:0] command_code;
    logic [7:0] length_code;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       payload_last;
  } res_t;

endpackage

/* rtl/xor_packet_deframer.sv */
// Top level of the XOR packet deframer: config port, frame core, result register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | in_valid / in_ready    | in_kind, in_rx_byte
//  result   | out_valid / out_ready  | out_status .. out_payload_last
//  config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle while results are taken; each result is registered
// when its input is accepted. Rate is set by the single frame-state update.
// rst_n (synchronous) returns to hunting with the reset register values.
// in_ready drops only while a held result is not taken; a result taken in the
// same cycle frees the register for the next transaction.
module xor_packet_deframer import xpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_source_id,
  output logic [7:0]        out_destination_id,
  output logic [7:0]        out_command_code,
  output logic [7:0]        out_length_code,
  output logic              out_payload_valid,
  output logic [7:0]        out_payload_byte,
  output logic [7:0]        out_payload_index,
  output logic              out_payload_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  xpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xpd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .kind    (in_kind),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_source_id      = res_r.source_id;
  assign out_destination_id = res_r.destination_id;
  assign out_command_code   = res_r.command_code;
  assign out_length_code    = res_r.length_code;
  assign out_payload_valid  = res_r.payload_valid;
  assign out_payload_byte   = res_r.payload_byte;
  assign out_payload_index  = res_r.payload_index;
  assign out_payload_last   = res_r.payload_last;

endmodule

/* rtl/xpd_cfg.sv */
// APB-style configuration register file for the deframer.
module xpd_cfg import xpd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte          <= START_RST;
      cfg_r.base_timeout_ms     <= BASE_RST;
      cfg_r.per_byte_timeout_ms <= PER_BYTE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_BYTE: cfg_r.start_byte          <= pwdata[7:0];
        REG_BASE_TO:    cfg_r.base_timeout_ms     <= pwdata[9:0];
        REG_PER_BYTE:   cfg_r.per_byte_timeout_ms <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE: prdata = {24'd0, cfg_r.start_byte};
      REG_BASE_TO:    prdata = {22'd0, cfg_r.base_timeout_ms};
      REG_PER_BYTE:   prdata = {28'd0, cfg_r.per_byte_timeout_ms};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/xpd_core.sv */
// Frame state and per-transaction result logic of the deframer.
module xpd_core import xpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output res_t       res
);

  phase_t      phase_r, phase_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  hdr_r [4];
  logic [7:0]  hdr_nxt [4];
  logic [10:0] elapsed_r, elapsed_nxt;
  logic [10:0] limit_r, limit_nxt;

  logic [8:0]  cnt_inc;
  logic [10:0] elapsed_inc;
  logic [12:0] pay_limit;
  logic        hdr_done;
  logic        pay_done;
  logic        expired;
  logic        start_hit;

  assign cnt_inc     = cnt_r + 9'd1;
  assign elapsed_inc = (elapsed_r < TICK_MAX) ? elapsed_r + 11'd1 : elapsed_r;
  assign expired     = elapsed_inc >= limit_r;
  assign start_hit   = rx_byte == cfg.start_byte;
  assign hdr_done    = cnt_inc >= 9'd4;
  assign pay_done    = cnt_inc >= ({1'b0, hdr_r[3]} + 9'd1);
  assign pay_limit   = 13'(rx_byte) * 13'(cfg.per_byte_timeout_ms)
                     + {3'd0, cfg.base_timeout_ms};

  always_comb begin
    phase_nxt = phase_r;
    if (kind == KIND_TICK) begin
      if (phase_r != PH_HUNT && expired) phase_nxt = PH_HUNT;
    end else begin
      unique case (phase_r)
        PH_HUNT:    if (start_hit) phase_nxt = PH_HEADER;
        PH_HEADER:  if (hdr_done) phase_nxt = PH_PAYLOAD;
        PH_PAYLOAD: if (pay_done) phase_nxt = PH_CHECK;
        PH_CHECK:   phase_nxt = PH_HUNT;
        default:    phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    xor_nxt     = xor_r;
    hdr_nxt     = hdr_r;
    elapsed_nxt = elapsed_r;
    limit_nxt   = limit_r;
    res.status        = ST_NONE;
    res.payload_valid = 1'b0;
    res.payload_byte  = 8'd0;
    res.payload_index = 8'd0;
    res.payload_last  = 1'b0;
    if (kind == KIND_TICK) begin
      if (phase_r != PH_HUNT) begin
        elapsed_nxt = elapsed_inc;
        if (expired) res.status = ST_TIMEOUT;
      end
    end else begin
      unique case (phase_r)
        PH_HUNT: begin
          if (start_hit) begin
            cnt_nxt     = 9'd0;
            xor_nxt     = 8'd0;
            elapsed_nxt = 11'd0;
            limit_nxt   = {1'b0, cfg.base_timeout_ms};
          end
        end
        PH_HEADER: begin
          xor_nxt             = xor_r ^ rx_byte;
          hdr_nxt[cnt_r[1:0]] = rx_byte;
          cnt_nxt             = cnt_inc;
          if (hdr_done) begin
            cnt_nxt     = 9'd0;
            elapsed_nxt = 11'd0;
            limit_nxt   = (pay_limit > 13'(TICK_MAX)) ? TICK_MAX : pay_limit[10:0];
          end
        end
        PH_PAYLOAD: begin
          xor_nxt           = xor_r ^ rx_byte;
          res.payload_valid = 1'b1;
          res.payload_byte  = rx_byte;
          res.payload_index = cnt_r[7:0];
          res.payload_last  = pay_done;
          cnt_nxt           = cnt_inc;
        end
        PH_CHECK: begin
          res.status = (rx_byte == xor_r) ? ST_OK : ST_CHK_ERR;
          cnt_nxt    = 9'd0;
        end
        default: ;
      endcase
    end
    res.source_id      = hdr_nxt[0];
    res.destination_id = hdr_nxt[1];
    res.command_code   = hdr_nxt[2];
    res.length_code    = hdr_nxt[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cnt_r     <= 9'd0;
      xor_r     <= 8'd0;
      hdr_r     <= '{default: 8'd0};
      elapsed_r <= 11'd0;
      limit_r   <= 11'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      xor_r     <= xor_nxt;
      hdr_r     <= hdr_nxt;
      elapsed_r <= elapsed_nxt;
      limit_r   <= limit_nxt;
    end
  end

endmodule
